FILE: sv/mefc_pkg.sv
// Package: types, constants and arithmetic helpers for the EQ filter cascade.
package mefc_pkg;

    localparam int CHANNELS = 16;
    localparam int BANDS    = 16;
    localparam int SLOTS    = 6;
    localparam int CH_W     = 4;
    localparam int BAND_W   = 4;
    localparam int IDX_W    = CH_W + BAND_W;
    localparam int NB_ALL   = CHANNELS * BANDS;
    localparam int CADDR_W  = IDX_W + 3;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_COEF   = 2'd1,
        CMD_MODE   = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_BYPASS = 2'd0,
        MODE_BIQUAD = 2'd1,
        MODE_SVF2   = 2'd2,
        MODE_SVF1   = 2'd3
    } band_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_LOAD,
        ST_CRD,
        ST_MUL,
        ST_ACC,
        ST_WB,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         channel;
        logic [3:0]         band;
        logic [2:0]         coef_slot;
        logic signed [31:0] coef_value;
        logic [1:0]         band_mode;
        logic signed [23:0] sample_in;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         out_channel;
        logic signed [23:0] sample_out;
    } out_item_t;

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -38'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [35:0] rnd(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd134217728;
        return 36'(t >>> 28);
    endfunction

endpackage

FILE: sv/mefc_mul.sv
// Registered 32x32 multiply with Q4.28 rounding.
module mefc_mul
    import mefc_pkg::*;
(
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [35:0] p
);
    logic signed [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign p = rnd(prod_reg);
endmodule

FILE: sv/multichannel_eq_filter_cascade.sv
// Top level: multichannel parametric EQ cascade with memory-held band state.
// One transaction at a time. A write command passes through the read and load
// states before the next accept. A sample walks bands 0 to min(band_count,16)-1
// of its channel; each band reads its mode and state from block memories. A
// bypassed band skips coefficients and multiplies; any other band reads its
// coefficients (one coefficient word a cycle), runs a sequence of single
// shared-multiplier steps and writes the state back. After reset a clearing
// pass over all 256 entries zeroes mode and state memories before the first
// item is accepted.
module multichannel_eq_filter_cascade
    import mefc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [4:0] cfg_data
);
    logic [4:0] band_count_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            band_count_reg <= 5'd10;
        else if (cfg_valid)
            band_count_reg <= cfg_data;
    end

    // memories
    logic [1:0]  mode_mem [NB_ALL];
    logic [31:0] s1_mem   [NB_ALL];
    logic [31:0] s2_mem   [NB_ALL];
    logic [31:0] coef_mem [NB_ALL*8];

    logic             st_we;
    logic [IDX_W-1:0] st_wa, st_ra;
    logic [1:0]       mode_wd, mode_rd;
    logic [31:0]      s1_wd, s2_wd, s1_rd, s2_rd;
    logic             c_we;
    logic [CADDR_W-1:0] c_wa, c_ra;
    logic [31:0]      c_wd, c_rd;

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            mode_mem[st_wa] <= mode_wd;
            s1_mem[st_wa]   <= s1_wd;
            s2_mem[st_wa]   <= s2_wd;
        end
        mode_rd <= mode_mem[st_ra];
        s1_rd   <= s1_mem[st_ra];
        s2_rd   <= s2_mem[st_ra];
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
            coef_mem[c_wa] <= c_wd;
        c_rd <= coef_mem[c_ra];
    end

    // control
    state_t state_reg, state_next;
    logic [IDX_W:0] clr_reg, clr_next;
    logic clearing;
    assign clearing = !clr_reg[IDX_W];

    in_item_t item_reg, item_next;
    logic [BAND_W:0] b_reg, b_next;
    logic [2:0] k_reg, k_next;
    logic [3:0] step_reg, step_next;
    logic [1:0] md_reg, md_next;
    logic signed [31:0] x_reg, x_next, s1_reg, s1_next, s2_reg, s2_next;
    logic signed [31:0] t0_reg, t0_next, t1_reg, t1_next;
    logic signed [37:0] acc_reg, acc_next;
    logic signed [31:0] c_reg [SLOTS];
    logic signed [31:0] c_next [SLOTS];
    out_item_t out_reg, out_next;
    logic ov_reg, ov_next;

    logic signed [31:0] ma, mb;
    logic signed [35:0] mp;
    mefc_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

    logic [BAND_W:0] nb;
    assign nb = (band_count_reg > 5'(BANDS)) ? (BAND_W+1)'(BANDS)
                                             : (BAND_W+1)'(band_count_reg);
    logic [IDX_W-1:0] cur_idx;
    assign cur_idx = {item_reg.channel, b_reg[BAND_W-1:0]};

    assign in_ready  = (state_reg == ST_IDLE) && !clearing && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        b_reg    <= b_next;
        k_reg    <= k_next;
        step_reg <= step_next;
        md_reg   <= md_next;
        x_reg    <= x_next;
        s1_reg   <= s1_next;
        s2_reg   <= s2_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        acc_reg  <= acc_next;
        out_reg  <= out_next;
        for (int i = 0; i < SLOTS; i++)
            c_reg[i] <= c_next[i];
    end

    // multiplier operand schedule per mode; step indexes the product,
    // which is registered in mefc_mul (issue at MUL, accumulate at ACC)
    always_comb
    begin
        ma = c_reg[0];
        mb = x_reg;
        unique case (md_reg)
            MODE_BIQUAD:
            begin
                unique case (step_reg)
                    4'd0: begin ma = c_reg[0]; mb = x_reg; end
                    4'd1: begin ma = c_reg[1]; mb = x_reg; end
                    4'd2: begin ma = c_reg[3]; mb = t0_reg; end
                    4'd3: begin ma = c_reg[2]; mb = x_reg; end
                    4'd4: begin ma = c_reg[4]; mb = t0_reg; end
                    default: ;
                endcase
            end
            MODE_SVF2:
            begin
                unique case (step_reg)
                    4'd0: begin ma = c_reg[0]; mb = s1_reg; end
                    4'd1: begin ma = c_reg[1]; mb = t0_reg; end
                    4'd2: begin ma = c_reg[1]; mb = s1_reg; end
                    4'd3: begin ma = c_reg[2]; mb = t0_reg; end
                    4'd4: begin ma = c_reg[3]; mb = x_reg; end
                    4'd5: begin ma = c_reg[4]; mb = t1_reg; end
                    4'd6: begin ma = c_reg[5]; mb = t0_reg; end
                    default: ;
                endcase
            end
            MODE_SVF1:
            begin
                unique case (step_reg)
                    4'd0: begin ma = c_reg[1]; mb = x_reg; end
                    4'd1: begin ma = c_reg[0]; mb = s1_reg; end
                    4'd2: begin ma = c_reg[3]; mb = x_reg; end
                    4'd3: begin ma = c_reg[4]; mb = t1_reg; end
                    4'd4: begin ma = c_reg[5]; mb = t0_reg; end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    logic [3:0] last_step;
    always_comb
    begin
        unique case (md_reg)
            MODE_BIQUAD: last_step = 4'd4;
            MODE_SVF2:   last_step = 4'd6;
            default:     last_step = 4'd4;
        endcase
    end

    logic [2:0] ncoef;
    assign ncoef = (md_reg == MODE_BIQUAD) ? 3'd5 : 3'd6;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        item_next  = item_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        step_next  = step_reg;
        md_next    = md_reg;
        x_next     = x_reg;
        s1_next    = s1_reg;
        s2_next    = s2_reg;
        t0_next    = t0_reg;
        t1_next    = t1_reg;
        acc_next   = acc_reg;
        out_next   = out_reg;
        ov_next    = ov_reg;
        for (int i = 0; i < SLOTS; i++)
            c_next[i] = c_reg[i];
        st_we   = 1'b0;
        st_wa   = cur_idx;
        st_ra   = cur_idx;
        mode_wd = md_reg;
        s1_wd   = s1_reg;
        s2_wd   = s2_reg;
        c_we    = 1'b0;
        c_wa    = {item_reg.channel, item_reg.band, item_reg.coef_slot};
        c_wd    = item_reg.coef_value;
        c_ra    = {cur_idx, k_reg};

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        if (clearing)
        begin
            st_we    = 1'b1;
            st_wa    = clr_reg[IDX_W-1:0];
            mode_wd  = MODE_BYPASS;
            s1_wd    = '0;
            s2_wd    = '0;
            clr_next = clr_reg + 1'b1;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        item_next = in_data;
                        b_next    = '0;
                        x_next    = 32'(in_data.sample_in);
                        unique case (cmd_t'(in_data.cmd))
                            CMD_SAMPLE:
                                state_next = (nb == '0) ? ST_OUT : ST_RD;
                            CMD_COEF, CMD_MODE:
                                state_next = ST_RD;
                            default: ;
                        endcase
                    end
                end
                ST_RD:
                begin
                    // state read for cur_idx (or write target) issued here
                    if (item_reg.cmd != CMD_SAMPLE)
                        st_ra = {item_reg.channel, item_reg.band};
                    k_next     = '0;
                    state_next = ST_LOAD;
                end
                ST_LOAD:
                begin
                    if (item_reg.cmd == CMD_COEF)
                    begin
                        c_we = (item_reg.coef_slot < 3'(SLOTS));
                        state_next = ST_IDLE;
                    end
                    else if (item_reg.cmd == CMD_MODE)
                    begin
                        st_wa = {item_reg.channel, item_reg.band};
                        if (mode_rd != item_reg.band_mode)
                        begin
                            st_we   = 1'b1;
                            mode_wd = item_reg.band_mode;
                            s1_wd   = '0;
                            s2_wd   = '0;
                        end
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        md_next = mode_rd;
                        s1_next = s1_rd;
                        s2_next = s2_rd;
                        k_next  = '0;
                        if (mode_rd == MODE_BYPASS)
                            state_next = ST_WB;
                        else
                            state_next = ST_CRD;
                    end
                end
                ST_CRD:
                begin
                    // c_ra issues slot k; data of slot k-1 arrives
                    if (k_reg != '0)
                        c_next[k_reg - 3'd1] = c_rd;
                    if (k_reg == ncoef)
                    begin
                        step_next  = '0;
                        // pre-work for svf2: t0 = v3 = sat(x - s2)
                        if (md_reg == MODE_SVF2)
                            t0_next = sat32(38'(x_reg) - 38'(s2_reg));
                        state_next = ST_MUL;
                    end
                    else
                        k_next = k_reg + 3'd1;
                end
                ST_MUL:
                begin
                    state_next = ST_ACC;
                end
                ST_ACC:
                begin
                    state_next = ST_MUL;
                    step_next  = step_reg + 4'd1;
                    unique case (md_reg)
                        MODE_BIQUAD:
                        begin
                            unique case (step_reg)
                                4'd0: t0_next = sat32(38'(mp) + 38'(s1_reg));
                                4'd1: acc_next = 38'(mp) + 38'(s2_reg);
                                4'd2: s1_next = sat32(acc_reg - 38'(mp));
                                4'd3: acc_next = 38'(mp);
                                default:
                                begin
                                    s2_next = sat32(acc_reg - 38'(mp));
                                    x_next  = t0_reg;
                                end
                            endcase
                        end
                        MODE_SVF2:
                        begin
                            unique case (step_reg)
                                4'd0: acc_next = 38'(mp);
                                4'd1: t1_next = sat32(acc_reg + 38'(mp));
                                4'd2: acc_next = 38'(mp) + 38'(s2_reg);
                                4'd3:
                                begin
                                    t0_next = sat32(acc_reg + 38'(mp));
                                    s1_next = sat32((38'(t1_reg) <<< 1) - 38'(s1_reg));
                                end
                                4'd4:
                                begin
                                    acc_next = 38'(mp);
                                    s2_next = sat32((38'(t0_reg) <<< 1) - 38'(s2_reg));
                                end
                                4'd5: acc_next = acc_reg + 38'(mp);
                                default: x_next = sat32(acc_reg + 38'(mp));
                            endcase
                        end
                        default:
                        begin
                            unique case (step_reg)
                                4'd0: acc_next = 38'(mp);
                                4'd1:
                                begin
                                    t1_next = sat32(acc_reg + 38'(mp));
                                    t0_next = sat32(38'(x_reg) - 38'(t1_next));
                                    s1_next = sat32((38'(t1_next) <<< 1) - 38'(s1_reg));
                                end
                                4'd2: acc_next = 38'(mp);
                                4'd3: acc_next = acc_reg + 38'(mp);
                                default: x_next = sat32(acc_reg + 38'(mp));
                            endcase
                        end
                    endcase
                    if (step_reg == last_step)
                        state_next = ST_WB;
                end
                ST_WB:
                begin
                    if (md_reg != MODE_BYPASS)
                        st_we = 1'b1;
                    b_next = b_reg + 1'b1;
                    if (b_reg + 1'b1 == nb)
                        state_next = ST_OUT;
                    else
                        state_next = ST_RD;
                end
                ST_OUT:
                begin
                    if (!ov_reg)
                    begin
                        ov_next = 1'b1;
                        out_next.out_channel = item_reg.channel;
                        if (x_reg > 32'sd8388607)
                            out_next.sample_out = 24'sh7fffff;
                        else if (x_reg < -32'sd8388608)
                            out_next.sample_out = 24'sh800000;
                        else
                            out_next.sample_out = x_reg[23:0];
                        state_next = ST_IDLE;
                    end
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end
endmodule
